FILE: hdl/http_request_framer_unit_macros.svh
// assertion macros for the http request framer
`ifndef HTTP_REQUEST_FRAMER_UNIT_MACROS_SVH
`define HTTP_REQUEST_FRAMER_UNIT_MACROS_SVH

// implication checked at every edge outside reset
`define HRF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hrf check failed");

// implication checked in the cycle after the antecedent
`define HRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hrf check failed");

`endif

FILE: hdl/hrf_pkg.sv
package hrf_pkg;

    typedef enum logic [1:0] {PH_REQ, PH_HDR, PH_BODY} phase_t;
    typedef enum logic [1:0] {KS_LEAD, KS_KEY, KS_TRAIL, KS_VALUE} key_stage_t;
    typedef enum logic [1:0] {VS_BEFORE, VS_SIGN, VS_DIGITS, VS_STOP} value_stage_t;

    localparam logic [1:0] ST_BUSY  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;
    localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

    typedef struct packed {
        logic [7:0] data;
        logic       is_cr;
        logic       is_lf;
    } item_t;

    typedef struct packed {
        phase_t       phase;
        logic         pending_cr;
        logic [1:0]   token_count;
        logic         inside_token;
        logic [2:0]   method_pos;
        logic         method_mismatch;
        logic         line_empty;
        logic [3:0]   key_pos;
        key_stage_t   key_stage;
        logic         key_mismatch;
        value_stage_t value_stage;
        logic         value_negative;
        logic         value_failed;
        logic [31:0]  value_accum;
        logic [31:0]  length_value;
        logic [31:0]  body_remaining;
    } pstate_t;

    typedef struct packed {
        pstate_t    st;
        logic [1:0] status;
    } end_res_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_body;
        logic [7:0]  body_byte;
        logic        method_post;
        logic [31:0] req_length;
    } result_t;

    function automatic logic is_space_any(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'd32) || (c == 8'd9);
    endfunction

    function automatic logic [7:0] post_char(input logic [2:0] p);
        case (p)
            3'd0: return 8'h50;
            3'd1: return 8'h4F;
            3'd2: return 8'h53;
            3'd3: return 8'h54;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] clen_char(input logic [3:0] p);
        case (p)
            4'd0: return 8'h63;
            4'd1: return 8'h6F;
            4'd2: return 8'h6E;
            4'd3: return 8'h74;
            4'd4: return 8'h65;
            4'd5: return 8'h6E;
            4'd6: return 8'h74;
            4'd7: return 8'h2D;
            4'd8: return 8'h6C;
            4'd9: return 8'h65;
            4'd10: return 8'h6E;
            4'd11: return 8'h67;
            4'd12: return 8'h74;
            4'd13: return 8'h68;
            default: return 8'h00;
        endcase
    endfunction

    function automatic pstate_t clear_line(input pstate_t s);
        pstate_t n;
        n = s;
        n.line_empty = 1'b1;
        n.key_pos = 4'd0;
        n.key_stage = KS_LEAD;
        n.key_mismatch = 1'b0;
        n.value_stage = VS_BEFORE;
        n.value_negative = 1'b0;
        n.value_failed = 1'b0;
        n.value_accum = 32'd0;
        return n;
    endfunction

    function automatic pstate_t reset_state();
        pstate_t n;
        n = '0;
        n.phase = PH_REQ;
        n.line_empty = 1'b1;
        n.key_stage = KS_LEAD;
        n.value_stage = VS_BEFORE;
        return n;
    endfunction

    function automatic pstate_t take_value_char(input pstate_t s, input logic [7:0] c);
        pstate_t n;
        logic [35:0] prod;
        n = s;
        prod = {4'd0, s.value_accum} * 36'd10 + {28'd0, c - 8'd48};
        if (s.value_stage == VS_STOP || s.value_failed) begin
            n = s;
        end else if (s.value_stage == VS_BEFORE && is_space_any(c)) begin
            n = s;
        end else if (s.value_stage == VS_BEFORE && (c == CH_PLUS || c == CH_MINUS)) begin
            n.value_negative = (c == CH_MINUS);
            n.value_stage = VS_SIGN;
        end else if (!(c >= 8'd48 && c <= 8'd57)) begin
            if (s.value_stage == VS_DIGITS) n.value_stage = VS_STOP;
            else n.value_failed = 1'b1;
        end else begin
            n.value_stage = VS_DIGITS;
            n.value_accum = (prod[35:32] != 4'd0) ? LEN_MAX : prod[31:0];
        end
        return n;
    endfunction

    function automatic pstate_t take_line_byte(input pstate_t s, input logic [7:0] c);
        pstate_t n;
        logic [7:0] lc;
        n = s;
        n.line_empty = 1'b0;
        lc = (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
        if (s.phase == PH_REQ) begin
            if (is_space_any(c)) begin
                n.inside_token = 1'b0;
            end else begin
                if (!s.inside_token) begin
                    n.inside_token = 1'b1;
                    if (s.token_count < 2'd3) n.token_count = s.token_count + 2'd1;
                end
                if (n.token_count == 2'd1) begin
                    if (s.method_pos >= 3'd4 || c != post_char(s.method_pos))
                        n.method_mismatch = 1'b1;
                    if (s.method_pos < 3'd5) n.method_pos = s.method_pos + 3'd1;
                end
            end
        end else if (s.key_stage == KS_VALUE) begin
            n = take_value_char(n, c);
        end else if (c == CH_COLON) begin
            n.key_stage = KS_VALUE;
        end else if (is_blank(c)) begin
            if (s.key_stage == KS_KEY) n.key_stage = KS_TRAIL;
        end else begin
            if (s.key_stage == KS_TRAIL) n.key_mismatch = 1'b1;
            n.key_stage = KS_KEY;
            if (s.key_pos >= 4'd14 || lc != clen_char(s.key_pos)) n.key_mismatch = 1'b1;
            if (s.key_pos < 4'd15) n.key_pos = s.key_pos + 4'd1;
        end
        return n;
    endfunction

    function automatic logic post_flag(input pstate_t s);
        return (s.phase != PH_REQ) && !s.method_mismatch && (s.method_pos == 3'd4);
    endfunction

    function automatic end_res_t end_line(input pstate_t s, input logic [31:0] max_len);
        end_res_t r;
        r.st = s;
        r.status = ST_BUSY;
        if (s.phase == PH_REQ) begin
            if (s.token_count < 2'd3) begin
                r.status = ST_ERROR;
            end else begin
                if (s.method_pos != 3'd4) r.st.method_mismatch = 1'b1;
                r.st.phase = PH_HDR;
                r.st = clear_line(r.st);
            end
        end else if (s.line_empty) begin
            if (post_flag(s) && s.length_value != 32'd0) begin
                if (s.length_value > max_len) begin
                    r.status = ST_ERROR;
                end else begin
                    r.st.phase = PH_BODY;
                    r.st.body_remaining = s.length_value;
                    r.st = clear_line(r.st);
                end
            end else begin
                r.status = ST_DONE;
            end
        end else begin
            if (s.key_stage == KS_VALUE && !s.key_mismatch && s.key_pos == 4'd14) begin
                if (s.value_failed || s.value_stage == VS_BEFORE || s.value_stage == VS_SIGN)
                    r.status = ST_ERROR;
                else if (s.value_negative && s.value_accum != 32'd0)
                    r.st.length_value = LEN_MAX;
                else
                    r.st.length_value = s.value_accum;
            end
            if (r.status == ST_BUSY) r.st = clear_line(r.st);
        end
        return r;
    endfunction

endpackage

FILE: hdl/http_request_framer_unit.sv
// byte-serial http request framer: one request byte per item on s_, one result per item on m_.
// a byte is taken every cycle unless a full queue holds the input; each byte passes a classify register,
// the queue and a result register. the parser keeps a single state word updated once per byte in the
// back end, and the queue lets the input keep flowing until its FIFO_DEPTH entries fill while the output is held.
// max_body_length sits at apb address 0; the user must write it only while the block is idle (not enforced).
`include "http_request_framer_unit_macros.svh"

module http_request_framer_unit #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], is_body[2], body_byte[10:3], method_post[11], req_length[43:12]
    output logic [47:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hrf_pkg::*;

    logic [31:0] max_body_length_reg;
    logic        f_valid, f_ready, b_valid, b_ready;
    item_t       f_item, b_item;
    result_t     res;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : max_body_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_body_length_reg <= MAX_BODY_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            max_body_length_reg <= pwdata;
        end
    end

    hrf_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_data(s_tdata),
        .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
    );

    hrf_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .aclk, .aresetn, .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
    );

    hrf_back u_back (
        .aclk, .aresetn, .max_body_length(max_body_length_reg),
        .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_result(res)
    );

    assign m_tdata = {4'd0, res.req_length, res.method_post, res.body_byte,
                      res.is_body, res.status};

    `HRF_ASSERT_IMP(a_status_code, m_tvalid, m_tdata[1:0] != 2'd3)
    `HRF_ASSERT_IMP(a_error_no_post, m_tvalid && m_tdata[1:0] == ST_ERROR, !m_tdata[11])
    `HRF_ASSERT_IMP(a_body_zero, m_tvalid && !m_tdata[2], m_tdata[10:3] == 8'd0)
    `HRF_ASSERT_NEXT(a_output_fed, !m_tvalid && !b_valid, !m_tvalid)
endmodule

FILE: hdl/hrf_front.sv
module hrf_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_data,
    output logic          q_valid,
    input  logic          q_ready,
    output hrf_pkg::item_t q_item
);
    import hrf_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign s_tready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_item   = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            item_reg.data  <= s_data;
            item_reg.is_cr <= (s_data == CH_CR);
            item_reg.is_lf <= (s_data == CH_LF);
        end
    end
endmodule

FILE: hdl/hrf_fifo.sv
module hrf_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  hrf_pkg::item_t wr_item,
    output logic           rd_valid,
    input  logic           rd_ready,
    output hrf_pkg::item_t rd_item
);
    import hrf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t           mem [DEPTH];
    logic [AW-1:0]   wptr_reg, rptr_reg;
    logic [CW-1:0]   count_reg;
    logic            push, pop;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem[rptr_reg];
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
            if (pop)  rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + AW'(1);
            if (push && !pop) count_reg <= count_reg + CW'(1);
            else if (pop && !push) count_reg <= count_reg - CW'(1);
        end
        if (push) mem[wptr_reg] <= wr_item;
    end
endmodule

FILE: hdl/hrf_back.sv
module hrf_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [31:0]      max_body_length,
    input  logic             q_valid,
    output logic             q_ready,
    input  hrf_pkg::item_t   q_item,
    output logic             m_valid,
    input  logic             m_ready,
    output hrf_pkg::result_t m_result
);
    import hrf_pkg::*;

    pstate_t  st_reg, st_next;
    result_t  res_reg, res_next;
    logic     valid_reg;
    end_res_t er;
    pstate_t  n;

    assign q_ready  = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = res_reg;

    always_comb begin
        n = st_reg;
        res_next = '0;
        er = '0;
        if (st_reg.phase == PH_BODY) begin
            res_next.is_body = 1'b1;
            res_next.body_byte = q_item.data;
            if (st_reg.body_remaining != 32'd0) n.body_remaining = st_reg.body_remaining - 32'd1;
            if (n.body_remaining == 32'd0) res_next.status = ST_DONE;
        end else if (st_reg.pending_cr) begin
            if (q_item.is_lf) begin
                n.pending_cr = 1'b0;
                er = end_line(n, max_body_length);
                n = er.st;
                res_next.status = er.status;
            end else begin
                n = take_line_byte(n, CH_CR);
                if (q_item.is_cr) begin
                    n.pending_cr = 1'b1;
                end else begin
                    n.pending_cr = 1'b0;
                    n = take_line_byte(n, q_item.data);
                end
            end
        end else if (q_item.is_cr) begin
            n.pending_cr = 1'b1;
        end else begin
            n = take_line_byte(n, q_item.data);
        end
        res_next.method_post = (res_next.status != ST_ERROR) && post_flag(n);
        res_next.req_length = n.length_value;
        st_next = (res_next.status != ST_BUSY) ? reset_state() : n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            st_reg    <= reset_state();
        end else if (q_ready) begin
            valid_reg <= q_valid;
            if (q_valid) st_reg <= st_next;
        end
        if (q_ready && q_valid) res_reg <= res_next;
    end
endmodule

FILE: tb/http_request_framer_unit_tb.sv
`timescale 1ns / 1ps

module http_request_framer_unit_tb;
    import hrf_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_BYTES = 280;
    localparam logic [31:0] POST_WORD = "POST";
    localparam logic [111:0] CLEN_WORD = "content-length";
    localparam logic [2:0] ADDR_MAX_BODY = 3'd0;
    localparam logic [2:0] ADDR_UNUSED = 3'd4;

    typedef struct {
        logic [7:0] b;
        bit         pin;
        logic [1:0] st;
    } byte_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;    // data_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // status[1:0], is_body[2], body_byte[10:3], method_post[11], req_length[43:12]
    logic [47:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    http_request_framer_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 aclk = ~aclk;

    // predictor state
    phase_t       ph;
    logic         pend_cr, in_tok, m_bad, l_empty, k_bad, v_neg, v_fail;
    logic [1:0]   tok_n;
    logic [2:0]   m_pos;
    logic [3:0]   k_pos;
    key_stage_t   k_stage;
    value_stage_t v_stage;
    logic [31:0]  v_acc, clen, body_left, max_body;

    byte_row_t   send_q[$];
    logic [47:0] framer_results_q[$];
    logic [1:0]  pinned_status_q[$];
    bit          pinned_q[$];
    bit          cur_pin = 1'b0;
    logic [1:0]  cur_st = ST_BUSY;
    int          idle_s = 0, idle_r = 0;
    int          errors = 0, n_in = 0, n_out = 0, n_done = 0, n_err = 0, n_body = 0;
    int          quiet = 0;
    logic [31:0] gen_max = MAX_BODY_RESET;

    byte_row_t header_rows[11] = '{
        '{8'h00, 0, ST_BUSY}, '{" ", 0, ST_BUSY}, '{"b", 0, ST_BUSY}, '{"\t", 0, ST_BUSY},
        '{8'hFF, 0, ST_BUSY}, '{CH_CR, 0, ST_BUSY}, '{CH_LF, 1, ST_BUSY},
        '{CH_CR, 0, ST_BUSY}, '{CH_LF, 1, ST_DONE},
        '{CH_CR, 0, ST_BUSY}, '{CH_LF, 1, ST_ERROR}
    };

    function automatic bit space_any(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    task automatic clear_line_state();
        l_empty = 1'b1; k_pos = 4'd0; k_stage = KS_LEAD; k_bad = 1'b0;
        v_stage = VS_BEFORE; v_neg = 1'b0; v_fail = 1'b0; v_acc = 32'd0;
    endtask

    task automatic clear_request_state();
        ph = PH_REQ; pend_cr = 1'b0; tok_n = 2'd0; in_tok = 1'b0;
        m_pos = 3'd0; m_bad = 1'b0; clen = 32'd0; body_left = 32'd0;
        clear_line_state();
    endtask

    function automatic bit post_seen();
        return ph != PH_REQ && !m_bad && m_pos == 3'd4;
    endfunction

    task automatic value_char(logic [7:0] c);
        logic [31:0] d;
        d = {24'd0, c} - 32'd48;
        if (v_stage == VS_STOP || v_fail) return;
        if (v_stage == VS_BEFORE) begin
            if (space_any(c)) return;
            if (c == CH_PLUS || c == CH_MINUS) begin
                v_neg = (c == CH_MINUS);
                v_stage = VS_SIGN;
                return;
            end
        end
        if (!(c >= "0" && c <= "9")) begin
            if (v_stage == VS_DIGITS) v_stage = VS_STOP;
            else v_fail = 1'b1;
            return;
        end
        v_stage = VS_DIGITS;
        if (v_acc > (LEN_MAX - d) / 32'd10) v_acc = LEN_MAX;
        else v_acc = v_acc * 32'd10 + d;
    endtask

    task automatic line_char(logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        l_empty = 1'b0;
        if (ph == PH_REQ) begin
            if (space_any(c)) begin
                in_tok = 1'b0;
                return;
            end
            if (!in_tok) begin
                in_tok = 1'b1;
                if (tok_n < 2'd3) tok_n++;
            end
            if (tok_n == 2'd1) begin
                if (m_pos >= 3'd4 || c != POST_WORD[31 - 8 * m_pos -: 8]) m_bad = 1'b1;
                if (m_pos < 3'd5) m_pos++;
            end
        end else if (k_stage == KS_VALUE) begin
            value_char(c);
        end else if (c == CH_COLON) begin
            k_stage = KS_VALUE;
        end else if (c == " " || c == "\t") begin
            if (k_stage == KS_KEY) k_stage = KS_TRAIL;
        end else begin
            if (k_stage == KS_TRAIL) k_bad = 1'b1;
            k_stage = KS_KEY;
            if (k_pos >= 4'd14 || lc != CLEN_WORD[111 - 8 * k_pos -: 8]) k_bad = 1'b1;
            if (k_pos < 4'd15) k_pos++;
        end
    endtask

    task automatic finish_line(output logic [1:0] st);
        st = ST_BUSY;
        if (ph == PH_REQ) begin
            if (tok_n < 2'd3) begin
                st = ST_ERROR;
                return;
            end
            if (m_pos != 3'd4) m_bad = 1'b1;
            ph = PH_HDR;
            clear_line_state();
        end else if (l_empty) begin
            if (post_seen() && clen != 32'd0) begin
                if (clen > max_body) begin
                    st = ST_ERROR;
                    return;
                end
                ph = PH_BODY;
                body_left = clen;
                clear_line_state();
            end else begin
                st = ST_DONE;
            end
        end else begin
            if (k_stage == KS_VALUE && !k_bad && k_pos == 4'd14) begin
                if (v_fail || v_stage == VS_BEFORE || v_stage == VS_SIGN) begin
                    st = ST_ERROR;
                    return;
                end
                clen = (v_neg && v_acc != 32'd0) ? LEN_MAX : v_acc;
            end
            clear_line_state();
        end
    endtask

    task automatic frame_byte(input logic [7:0] c, output logic [47:0] res);
        logic [1:0] st;
        logic       body;
        logic [7:0] bout;
        st = ST_BUSY; body = 1'b0; bout = 8'd0;
        if (ph == PH_BODY) begin
            body = 1'b1;
            bout = c;
            if (body_left != 32'd0) body_left--;
            if (body_left == 32'd0) st = ST_DONE;
        end else if (pend_cr) begin
            if (c == CH_LF) begin
                pend_cr = 1'b0;
                finish_line(st);
            end else begin
                line_char(CH_CR);
                if (c == CH_CR) begin
                    pend_cr = 1'b1;
                end else begin
                    pend_cr = 1'b0;
                    line_char(c);
                end
            end
        end else if (c == CH_CR) begin
            pend_cr = 1'b1;
        end else begin
            line_char(c);
        end
        res = {4'd0, clen, (st != ST_ERROR && post_seen()), bout, body, st};
        if (st != ST_BUSY) clear_request_state();
    endtask

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        errors++;
        $display("item %0d: %s got %h want %h", n_out, what, got, want);
    endtask

    task automatic queue_row(byte_row_t r);
        send_q = {send_q, r};
    endtask

    // monitor and checker
    always @(posedge aclk) begin
        logic [47:0] want;
        logic [1:0]  pst;
        bit          pinned;
        if (!aresetn) begin
            clear_request_state();
            max_body = MAX_BODY_RESET;
        end else begin
            quiet++;
            if (psel && penable && pwrite && pready) begin
                quiet = 0;
                if (paddr == ADDR_MAX_BODY) max_body = pwdata;
            end
            if (s_tvalid && s_tready) begin
                quiet = 0;
                n_in++;
                frame_byte(s_tdata, want);
                framer_results_q = {framer_results_q, want};
                pinned_q = {pinned_q, cur_pin};
                pinned_status_q = {pinned_status_q, cur_st};
            end
            if (m_tvalid && m_tready) begin
                quiet = 0;
                n_out++;
                if (framer_results_q.size() == 0) begin
                    report_mismatch("unexpected", m_tdata, 48'd0);
                end else begin
                    want = framer_results_q.pop_front();
                    pinned = pinned_q.pop_front();
                    pst = pinned_status_q.pop_front();
                    if (m_tdata[1:0] != want[1:0]) report_mismatch("status", m_tdata, want);
                    if (pinned && m_tdata[1:0] != pst)
                        report_mismatch("directed status", m_tdata, {46'd0, pst});
                    if (m_tdata[2] != want[2]) report_mismatch("is_body", m_tdata, want);
                    if (m_tdata[10:3] != want[10:3])
                        report_mismatch("body_byte", m_tdata, want);
                    if (m_tdata[11] != want[11])
                        report_mismatch("method_post", m_tdata, want);
                    if (m_tdata[43:12] != want[43:12])
                        report_mismatch("req_length", m_tdata, want);
                    if (want[1:0] == ST_DONE) n_done++;
                    if (want[1:0] == ST_ERROR) n_err++;
                    if (want[2]) n_body++;
                end
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("http_request_framer_unit: mismatch");
                $finish;
            end
        end
    end

    // byte sender and result sink
    always @(posedge aclk) begin
        byte_row_t r;
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (send_q.size() > 0 && $urandom_range(99) >= idle_s) begin
                    r = send_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= r.b;
                    cur_pin <= r.pin;
                    cur_st <= r.st;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= idle_r);
        end
    end

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) queue_row('{s[i], 1'b0, ST_BUSY});
    endtask

    function automatic string pick_sep();
        case ($urandom_range(3))
            0: return "\t";
            1: return "  ";
            default: return " ";
        endcase
    endfunction

    task automatic gen_request();
        string       line, keyw, valw;
        int          ntok, sel, v;
        bit          is_post, broken, matched, bad_val;
        logic [31:0] len;
        broken = 0;
        len = 32'd0;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(5, 20)) queue_row('{8'($urandom_range(255)), 1'b0, ST_BUSY});
            return;
        end
        sel = $urandom_range(5);
        case (sel)
            0, 1, 2: line = "POST";
            3: line = "GET";
            4: line = "post";
            default: line = "POSTS";
        endcase
        is_post = sel < 3;
        ntok = ($urandom_range(7) == 0) ? 2 : 3 + $urandom_range(1);
        if (ntok < 3) broken = 1;
        for (int t = 1; t < ntok; t++)
            line = {line, pick_sep(), ($urandom_range(5) == 0) ? "/a\rb" : "/x"};
        push_text({line, "\r\n"});
        repeat ($urandom_range(3)) begin
            matched = 0;
            bad_val = 0;
            v = $urandom_range(40);
            case ($urandom_range(7))
                0: keyw = "Host";
                1: keyw = "no colon here";
                2: keyw = "content length";
                default: begin
                    sel = $urandom_range(3);
                    case (sel)
                        0: keyw = "Content-Length";
                        1: keyw = "content-length";
                        2: keyw = " CONTENT-LENGTH\t";
                        default: keyw = "Content-Lengthx";
                    endcase
                    matched = sel < 3;
                end
            endcase
            case ($urandom_range(9))
                0: valw = $sformatf("+%0d", v);
                1: begin valw = "-0"; v = 0; end
                2: valw = $sformatf("\t%0dabc", v);
                3: begin valw = ""; bad_val = 1; end
                4: begin valw = " x"; bad_val = 1; end
                5: begin valw = "+"; bad_val = 1; end
                6: begin
                    if (gen_max != LEN_MAX) begin
                        valw = ($urandom_range(1) == 0) ? "99999999999" : "-7";
                        v = -1;
                    end else begin
                        valw = $sformatf("%0d", v);
                    end
                end
                default: valw = $sformatf(" %0d", v);
            endcase
            if (keyw == "no colon here") push_text({keyw, "\r\n"});
            else push_text({keyw, ":", valw, "\r\n"});
            if (matched) begin
                if (bad_val) broken = 1;
                else len = (v < 0) ? LEN_MAX : v;
            end
        end
        push_text("\r\n");
        if (!broken && is_post && len != 32'd0 && len <= gen_max)
            repeat (len) queue_row('{8'($urandom_range(255)), 1'b0, ST_BUSY});
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (send_q.size() > 0 || s_tvalid || framer_results_q.size() > 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    logic [31:0] limits[6] = '{MAX_BODY_RESET, 32'd0, LEN_MAX, 32'd10, 32'd40, 32'd1048576};

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                drain();
                apb_write(ADDR_MAX_BODY, limits[p]);
                if (p == 1) apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
                gen_max = limits[p];
            end
            idle_s = (p < 2) ? 30 : (p < 4) ? 66 : 0;
            idle_r = (p < 2) ? 66 : (p < 4) ? 30 : 0;
            @(negedge aclk);
            if (p == 0) foreach (header_rows[i]) queue_row(header_rows[i]);
            while (send_q.size() < PHASE_BYTES) gen_request();
        end
        drain();
        $display("%0d bytes in, %0d results: %0d complete, %0d errors, %0d body bytes",
                 n_in, n_out, n_done, n_err, n_body);
        $display("six body limits, both idling patterns and full rate were exercised");
        if (errors == 0) begin
            $display("http_request_framer_unit: match");
        end else begin
            $display("http_request_framer_unit: mismatch");
        end
        $finish;
    end

endmodule
